// ===== rtl/tqb_pkg.sv =====
package tqb_pkg;

  // default sizes
  localparam int TEXTURE_WORDS_DEF = 4096;
  localparam int FRAME_DIM_DEF     = 2048;

  // configuration register indexes
  typedef enum logic [3:0] {
    REG_ORIGIN_X    = 4'd0,
    REG_ORIGIN_Y    = 4'd1,
    REG_XAXIS_INV_X = 4'd2,
    REG_XAXIS_INV_Y = 4'd3,
    REG_YAXIS_INV_X = 4'd4,
    REG_YAXIS_INV_Y = 4'd5,
    REG_TEX_WIDTH   = 4'd6,
    REG_TEX_HEIGHT  = 4'd7
  } reg_idx_e;

  // request kinds
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_SHADE = 1'b1
  } req_e;

  // control that travels with every word down the pipe
  typedef struct packed {
    logic        valid;
    logic        load;
    logic        cov;
    logic [10:0] x;
    logic [10:0] y;
    logic [31:0] data;
    logic [11:0] tidx;
  } tag_t;

  // quad setup, texture sizes already clamped
  typedef struct packed {
    logic signed [19:0] ox;
    logic signed [19:0] oy;
    logic signed [22:0] xix;
    logic signed [22:0] xiy;
    logic signed [22:0] yix;
    logic signed [22:0] yiy;
    logic [6:0]         w;
    logic [6:0]         h;
  } cfg_t;

endpackage

// ===== rtl/textured_quad_bilinear_blend.sv =====
// a shade word passes the coord, fetch and blend pipelines and then the output
// register before its result is on the output
// throughput: one word per cycle while in_stall_o is low, loads and shades alike; loads give no result
// rate is set by the pipeline: the four texel reads use four store copies
// a two-entry output stage (output register plus skid) decouples out_stall_i
// reset clears pipeline valid bits and the setup registers; the texture store
// is not cleared and holds nothing defined until loaded
module textured_quad_bilinear_blend
  import tqb_pkg::*;
#(
  parameter int TEXTURE_WORDS = TEXTURE_WORDS_DEF,
  parameter int FRAME_DIM     = FRAME_DIM_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [11:0] texel_index_i,
  input  logic [31:0] texel_value_i,
  input  logic [10:0] pixel_x_i,
  input  logic [10:0] pixel_y_i,
  input  logic [31:0] dest_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] new_pixel_o,
  output logic        covered_o,
  output logic [10:0] out_x_o,
  output logic [10:0] out_y_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [22:0] cfg_data_i
);

  logic signed [19:0] ox_q, oy_q;
  logic signed [22:0] xix_q, xiy_q, yix_q, yiy_q;
  logic [6:0]  tw_q, th_q, w_c, h_c;
  cfg_t        cfg;
  tag_t        tag_in, tag_c, tag_f, tag_b;
  logic        en;
  logic [5:0]  ix, iy;
  logic [7:0]  fx, fy;
  logic [31:0] texel [4];
  logic [16:0] wt [4];
  logic [31:0] pix_b;
  logic        res_v;
  logic        out_valid_q, skid_q;
  logic [31:0] out_pix_q, skid_pix_q;
  logic        out_cov_q, skid_cov_q;
  logic [10:0] out_x_q, out_y_q, skid_x_q, skid_y_q;

  // setup register writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q  <= '0;
      oy_q  <= '0;
      xix_q <= '0;
      xiy_q <= '0;
      yix_q <= '0;
      yiy_q <= '0;
      tw_q  <= 7'd64;
      th_q  <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ORIGIN_X:    ox_q  <= cfg_data_i[19:0];
        REG_ORIGIN_Y:    oy_q  <= cfg_data_i[19:0];
        REG_XAXIS_INV_X: xix_q <= cfg_data_i;
        REG_XAXIS_INV_Y: xiy_q <= cfg_data_i;
        REG_YAXIS_INV_X: yix_q <= cfg_data_i;
        REG_YAXIS_INV_Y: yiy_q <= cfg_data_i;
        REG_TEX_WIDTH:   tw_q  <= cfg_data_i[6:0];
        REG_TEX_HEIGHT:  th_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // texture size clamped to 4..64
  always_comb begin
    w_c = tw_q;
    h_c = th_q;
    if (tw_q < 7'd4) begin
      w_c = 7'd4;
    end else if (tw_q > 7'd64) begin
      w_c = 7'd64;
    end
    if (th_q < 7'd4) begin
      h_c = 7'd4;
    end else if (th_q > 7'd64) begin
      h_c = 7'd64;
    end
  end

  assign cfg = '{ox: ox_q, oy: oy_q, xix: xix_q, xiy: xiy_q, yix: yix_q,
                 yiy: yiy_q, w: w_c, h: h_c};

  // pipeline advances unless the skid entry is full
  assign en         = !skid_q;
  assign in_stall_o = skid_q;

  // incoming word, off-frame pixels are never covered
  always_comb begin
    tag_in.valid = in_valid_i && en;
    tag_in.load  = (req_type_i == REQ_LOAD);
    tag_in.cov   = (req_type_i == REQ_SHADE) && (32'(pixel_x_i) < FRAME_DIM) &&
                   (32'(pixel_y_i) < FRAME_DIM);
    tag_in.x     = pixel_x_i;
    tag_in.y     = pixel_y_i;
    tag_in.data  = (req_type_i == REQ_LOAD) ? texel_value_i : dest_pixel_i;
    tag_in.tidx  = texel_index_i;
  end

  tqb_coord u_coord (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .cfg_i (cfg),
    .tag_i (tag_in),
    .tag_o (tag_c),
    .ix_o  (ix),
    .iy_o  (iy),
    .fx_o  (fx),
    .fy_o  (fy)
  );

  tqb_fetch #(
    .TEXTURE_WORDS(TEXTURE_WORDS)
  ) u_fetch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .w_i    (w_c),
    .tag_i  (tag_c),
    .ix_i   (ix),
    .iy_i   (iy),
    .fx_i   (fx),
    .fy_i   (fy),
    .tag_o  (tag_f),
    .texel_o(texel),
    .wt_o   (wt)
  );

  tqb_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_f),
    .texel_i(texel),
    .wt_i   (wt),
    .tag_o  (tag_b),
    .pixel_o(pix_b)
  );

  assign res_v = en && tag_b.valid && !tag_b.load;

  // output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= skid_q || res_v;
      skid_q      <= 1'b0;
    end else if (res_v) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_q) begin
        out_pix_q <= skid_pix_q;
        out_cov_q <= skid_cov_q;
        out_x_q   <= skid_x_q;
        out_y_q   <= skid_y_q;
      end else begin
        out_pix_q <= pix_b;
        out_cov_q <= tag_b.cov;
        out_x_q   <= tag_b.x;
        out_y_q   <= tag_b.y;
      end
    end else if (res_v) begin
      skid_pix_q <= pix_b;
      skid_cov_q <= tag_b.cov;
      skid_x_q   <= tag_b.x;
      skid_y_q   <= tag_b.y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_pixel_o = out_pix_q;
  assign covered_o   = out_cov_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;

  // skid entry only fills behind a held output word
  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_valid_q)
    else $error("skid entry full without an output word");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled while output was free");

  // a frozen pipeline keeps its last stage
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(tag_b))
    else $error("pipeline moved while frozen");

endmodule

// ===== rtl/tqb_ram.sv =====
module tqb_ram
  import tqb_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = TEXTURE_WORDS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tqb_coord.sv =====
module tqb_coord
  import tqb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  cfg_t       cfg_i,
  input  tag_t       tag_i,
  output tag_t       tag_o,
  output logic [5:0] ix_o,
  output logic [5:0] iy_o,
  output logic [7:0] fx_o,
  output logic [7:0] fy_o
);

  localparam logic [37:0] TX_BIAS = 38'd3 << 29;
  localparam logic signed [44:0] ONE_Q30 = 45'sd1073741824;

  tag_t t1_q, t2_q, t3_q, t4_q, t3_d;
  logic signed [20:0] px1_q, py1_q, px1_d, py1_d;
  logic signed [43:0] m0_q, m1_q, m2_q, m3_q;
  logic signed [44:0] u_d, v_d;
  logic [30:0] u3_q, v3_q;
  logic        in_d;
  logic [5:0]  wm3, hm3, ix_d, iy_d, ix4_q, iy4_q;
  logic [37:0] tx_d, ty_d;
  logic [7:0]  fx4_q, fy4_q;

  // pixel relative to origin, Q.8
  assign px1_d = $signed({2'b00, tag_i.x, 8'h00}) - 21'(cfg_i.ox);
  assign py1_d = $signed({2'b00, tag_i.y, 8'h00}) - 21'(cfg_i.oy);

  // u, v sums and coverage test
  assign u_d  = 45'(m0_q) + 45'(m1_q);
  assign v_d  = 45'(m2_q) + 45'(m3_q);
  assign in_d = !u_d[44] && (u_d <= ONE_Q30) && !v_d[44] && (v_d <= ONE_Q30);

  // stage three word with the coverage result folded in
  always_comb begin
    t3_d     = t2_q;
    t3_d.cov = t2_q.cov && in_d;
  end

  // texel position, integer part clamped to the last column or row
  assign wm3  = 6'(cfg_i.w - 7'd3);
  assign hm3  = 6'(cfg_i.h - 7'd3);
  assign tx_d = 38'(u3_q) * 38'(wm3) + TX_BIAS;
  assign ty_d = 38'(v3_q) * 38'(hm3) + TX_BIAS;

  always_comb begin
    ix_d = tx_d[35:30];
    iy_d = ty_d[35:30];
    if (tx_d[37:30] > 8'(cfg_i.w - 7'd1)) begin
      ix_d = 6'(cfg_i.w - 7'd1);
    end
    if (ty_d[37:30] > 8'(cfg_i.h - 7'd1)) begin
      iy_d = 6'(cfg_i.h - 7'd1);
    end
  end

  // control of the four stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= '0;
    end else if (en_i) begin
      t1_q <= tag_i;
      t2_q <= t1_q;
      t3_q <= t3_d;
      t4_q <= t3_q;
    end
  end

  // arithmetic of the four stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px1_q <= px1_d;
      py1_q <= py1_d;
      m0_q  <= 44'(px1_q) * 44'(cfg_i.xix);
      m1_q  <= 44'(py1_q) * 44'(cfg_i.xiy);
      m2_q  <= 44'(px1_q) * 44'(cfg_i.yix);
      m3_q  <= 44'(py1_q) * 44'(cfg_i.yiy);
      u3_q  <= u_d[30:0];
      v3_q  <= v_d[30:0];
      ix4_q <= ix_d;
      iy4_q <= iy_d;
      fx4_q <= tx_d[29:22];
      fy4_q <= ty_d[29:22];
    end
  end

  assign tag_o = t4_q;
  assign ix_o  = ix4_q;
  assign iy_o  = iy4_q;
  assign fx_o  = fx4_q;
  assign fy_o  = fy4_q;

endmodule

// ===== rtl/tqb_fetch.sv =====
module tqb_fetch
  import tqb_pkg::*;
#(
  parameter int TEXTURE_WORDS = TEXTURE_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [6:0]  w_i,
  input  tag_t        tag_i,
  input  logic [5:0]  ix_i,
  input  logic [5:0]  iy_i,
  input  logic [7:0]  fx_i,
  input  logic [7:0]  fy_i,
  output tag_t        tag_o,
  output logic [31:0] texel_o [4],
  output logic [16:0] wt_o [4]
);

  localparam int AW = $clog2(TEXTURE_WORDS);
  localparam longint unsigned RECIP =
    ((64'd1 << 30) + 64'(TEXTURE_WORDS) - 64'd1) / 64'(TEXTURE_WORDS);

  tag_t t1_q, t2_q, t3_q, t4_q;
  logic [11:0] base1_q;
  logic [6:0]  w1_q;
  logic [8:0]  gx, gy;
  logic [16:0] c1_q [4];
  logic [16:0] c2_q [4];
  logic [16:0] c3_q [4];
  logic [16:0] c4_q [4];
  logic [12:0] a_d  [5];
  logic [12:0] a2_q [5];
  logic [12:0] q2_q [5];
  logic [17:0] r_d  [5];
  logic [AW-1:0] ra3_q [5];

  assign gx = 9'd256 - 9'(fx_i);
  assign gy = 9'd256 - 9'(fy_i);

  // four neighbor addresses, fifth slot is the load address
  always_comb begin
    a_d[0] = 13'(base1_q);
    a_d[1] = 13'(base1_q) + 13'd1;
    a_d[2] = 13'(base1_q) + 13'(w1_q);
    a_d[3] = 13'(base1_q) + 13'(w1_q) + 13'd1;
    a_d[4] = 13'(t1_q.tidx);
  end

  // wrap to the store size: remainder after the reciprocal quotient
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      r_d[k] = 18'(a2_q[k]) - 18'(q2_q[k]) * 18'(TEXTURE_WORDS);
      if (r_d[k] >= 18'(TEXTURE_WORDS)) begin
        r_d[k] = r_d[k] - 18'(TEXTURE_WORDS);
      end
    end
  end

  // control of the four stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= '0;
    end else if (en_i) begin
      t1_q <= tag_i;
      t2_q <= t1_q;
      t3_q <= t2_q;
      t4_q <= t3_q;
    end
  end

  // base address, weights, quotient, remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base1_q <= 12'(13'(iy_i) * 13'(w_i) + 13'(ix_i));
      w1_q    <= w_i;
      c1_q[0] <= 17'(18'(gx) * 18'(gy));
      c1_q[1] <= 17'(18'(fx_i) * 18'(gy));
      c1_q[2] <= 17'(18'(gx) * 18'(fy_i));
      c1_q[3] <= 17'(18'(fx_i) * 18'(fy_i));
      for (int k = 0; k < 5; k++) begin
        a2_q[k]  <= a_d[k];
        q2_q[k]  <= 13'((44'(a_d[k]) * 44'(RECIP)) >> 30);
        ra3_q[k] <= r_d[k][AW-1:0];
      end
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  // one store copy per neighbor, every load writes all copies
  for (genvar k = 0; k < 4; k++) begin : g_store
    tqb_ram #(
      .WIDTH(32),
      .DEPTH(TEXTURE_WORDS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (en_i && t3_q.valid && t3_q.load),
      .waddr_i(ra3_q[4]),
      .wdata_i(t3_q.data),
      .re_i   (en_i),
      .raddr_i(ra3_q[k]),
      .rdata_o(texel_o[k])
    );
  end

  assign tag_o = t4_q;
  assign wt_o  = c4_q;

endmodule

// ===== rtl/tqb_blend.sv =====
module tqb_blend
  import tqb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  tag_t        tag_i,
  input  logic [31:0] texel_i [4],
  input  logic [16:0] wt_i [4],
  output tag_t        tag_o,
  output logic [31:0] pixel_o
);

  localparam logic [23:0] FULL = 24'd16711680;
  localparam logic [49:0] HALF = 50'd255 << 31;

  tag_t t1_q, t2_q, t3_q;
  logic [23:0] bl_d [4];
  logic [23:0] bl1_q [4];
  logic [31:0] p1_q [4];
  logic [47:0] p2_q [4];
  logic [49:0] n_d [4];
  logic [17:0] m_d [4];
  logic [7:0]  res_d [4];
  logic [31:0] pix3_q;
  logic [26:0] acc;

  // bilinear filter, channel 0 is red
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        acc = acc + 27'(texel_i[k][8*ch +: 8]) * 27'(wt_i[k]);
      end
      bl_d[ch] = acc[23:0];
    end
  end

  // round to a byte: divide by 255 * 2^32
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      n_d[ch]   = (50'(p1_q[ch]) << 16) + 50'(p2_q[ch]) + HALF;
      m_d[ch]   = n_d[ch][49:32];
      res_d[ch] = 8'((m_d[ch] + (m_d[ch] >> 8) + 18'd1) >> 8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
    end else if (en_i) begin
      t1_q <= tag_i;
      t2_q <= t1_q;
      t3_q <= t2_q;
    end
  end

  // products of the blend, dest byte for channel ch sits at 31-8*ch
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bl1_q   <= bl_d;
      for (int ch = 0; ch < 4; ch++) begin
        p1_q[ch] <= 32'(t1_q.data[31-8*ch -: 8]) * 32'(FULL - bl1_q[3]);
        p2_q[ch] <= 48'(bl1_q[ch]) * 48'(bl1_q[3]);
      end
      if (t2_q.cov) begin
        pix3_q <= {res_d[0], res_d[1], res_d[2], res_d[3]};
      end else begin
        pix3_q <= t2_q.data;
      end
    end
  end

  assign tag_o   = t3_q;
  assign pixel_o = pix3_q;

endmodule
